>>> src/insertion_sorter_assert.svh
// Assertion macros shared by the insertion sorter RTL.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

`ifndef SYNTHESIS

// Check prop at every rising clk edge outside reset.
`define INSORT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("insertion sorter check failed");

// Check prop at every rising clk edge, reset included.
`define INSORT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("insertion sorter check failed");

`else

`define INSORT_ASSERT(label, clk, rst, prop)
`define INSORT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> src/insort_pkg.sv
// Types and constants of the insertion sorter.
package insort_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;    // insert value into the chain
    logic  pop;    // shift the chain down by one place
    data_t value;  // value being inserted
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

>>> src/insertion_sorter.sv
// Insertion sorter top level: cell chain, control and output register.
// An item is inserted in the cycle it transfers, unless the chain is full; one item per cycle while filling.
// After the item marked last, the state register moves to drain and the stored entries then
// leave one per cycle while the output is not stalled, each loaded into the output register;
// input is held off until the final pop.
// Reset: synchronous, clears all cell valid bits, the sticky overflow flag and the output valid bit.
module insertion_sorter
  import insort_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  data_t       value,
  input  logic        last,
  output logic        sorted_valid,
  input  logic        sorted_ready,
  output data_t       sorted_value,
  output logic        last_out,
  output logic        overflow
);

`include "insertion_sorter_assert.svh"

  state_t      state;
  state_t      state_next;
  logic        dropped;
  cell_ctl_t   ctl;
  logic        accept;
  logic        pop;
  logic        full;

  data_t       cell_value [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_ge;

  // Accept input only while filling; a full chain drops the value.
  assign ready  = (state == ST_FILL);
  assign accept = valid && ready;
  assign full   = cell_valid[DEPTH-1];

  // In drain, pop cell 0 whenever the output register is free or being drained.
  assign pop = (state == ST_DRAIN) && (!sorted_valid || sorted_ready);

  assign ctl.ins   = accept && !full;
  assign ctl.pop   = pop;
  assign ctl.value = value;

  // Chain of cells: each takes its left neighbor or the new value on insert, its right on pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t l_value;
    logic  l_valid;
    logic  l_ge;
    data_t r_value;
    logic  r_valid;

    if (i == 0) begin : g_first
      assign l_value = value;
      assign l_valid = 1'b1;
      assign l_ge    = 1'b0;
    end else begin : g_mid
      assign l_value = cell_value[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_ge    = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_below
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end

    insort_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .left_ge     (l_ge),
      .right_value (r_value),
      .right_valid (r_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .ge          (cell_ge[i])
    );
  end

  // Advance to drain on the last transfer; return to fill on the final pop.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (accept && last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pop && !cell_valid[1]) state_next = ST_FILL;
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Sticky overflow: set on a dropped value, clear with the final pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
    end else if (pop && !cell_valid[1]) begin
      dropped <= 1'b0;
    end else if (accept && full) begin
      dropped <= 1'b1;
    end
  end

  // Output register: hold while stalled, load on each pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
    end else if (pop) begin
      sorted_valid <= 1'b1;
    end else if (sorted_ready) begin
      sorted_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sorted_value <= cell_value[0];
      last_out     <= !cell_valid[1];
      overflow     <= dropped;
    end
  end

  // Drain never runs on an empty chain.
  `INSORT_ASSERT(a_drain_nonempty, clk, rst, (state == ST_DRAIN) |-> cell_valid[0])
  // The final pop empties the chain and clears the overflow flag.
  `INSORT_ASSERT(a_final_pop_empties, clk, rst, (pop && !cell_valid[1]) |=> !cell_valid[0])
  `INSORT_ASSERT(a_final_pop_clears, clk, rst, (pop && !cell_valid[1]) |=> !dropped)
  // A waiting result stays valid and holds its value until it transfers.
  `INSORT_ASSERT(a_hold_valid, clk, rst, (sorted_valid && !sorted_ready) |=> sorted_valid)
  `INSORT_ASSERT(a_hold_value, clk, rst, (sorted_valid && !sorted_ready) |=> $stable(sorted_value))

endmodule

>>> src/insort_cell.sv
// One cell of the insertion chain: holds one sorted entry.
module insort_cell
  import insort_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  data_t     left_value,
  input  logic      left_valid,
  input  logic      left_ge,
  input  data_t     right_value,
  input  logic      right_valid,
  output data_t     value,
  output logic      valid,
  output logic      ge
);

  // Empty cells, and entries strictly greater than the new value, move up.
  assign ge = !valid || (value > ctl.value);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      value <= right_value;
    end else if (ctl.ins && ge) begin
      value <= left_ge ? left_value : ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end else if (ctl.ins) begin
      valid <= valid | left_valid;
    end
  end

endmodule
